// File: src/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and character constants for the order record parser.
// ----------------------------------------------------------------------------
package cpr_pkg;

	// Character codes
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Field count bounds
	localparam logic [2:0] REQ_FIELDS = 3'd4;
	localparam logic [2:0] MAX_FIELDS = 3'd5;

	// Field positions
	localparam logic [2:0] F_REQUEST  = 3'd0;
	localparam logic [2:0] F_USER     = 3'd1;
	localparam logic [2:0] F_ITEM     = 3'd2;
	localparam logic [2:0] F_QUANTITY = 3'd3;
	localparam logic [2:0] F_TIME     = 3'd4;

	// Input item class, decided by the front end
	typedef enum logic [1:0] {
		CLS_DIGIT = 2'd0,
		CLS_COMMA = 2'd1,
		CLS_OTHER = 2'd2,
		CLS_END   = 2'd3
	} cls_t;

	// Classified item handed from front to back
	typedef struct packed {
		cls_t       cls;
		logic [3:0] digit;
	} cmd_t;

	// One finished record
	typedef struct packed {
		logic        valid_res;
		logic [63:0] req_id;
		logic [63:0] user_id;
		logic [31:0] item_id;
		logic [31:0] quantity;
		logic [63:0] timestamp;
		logic [1:0]  lane;
	} res_t;

endpackage

// File: src/cpr_fifo.sv
// ----------------------------------------------------------------------------
// cpr_fifo
// Small register queue with full/empty flags; head item shown on rdata.
// ----------------------------------------------------------------------------
module cpr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/cpr_front.sv
// ----------------------------------------------------------------------------
// cpr_front
// Input stage: takes one byte item a cycle while the queue below has room,
// classifies it and registers it.
module cpr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          kind,
	input  logic [7:0]    byte_value,
	output logic          cmd_push,
	output cpr_pkg::cmd_t cmd,
	input  logic          cmd_full
);
	import cpr_pkg::*;

	logic       valid_s1;
	cmd_t       cmd_s1;
	cmd_t       cls_in;
	logic       advance;
	logic [7:0] digit_off;

	// Stage moves when empty or when the queue takes its item
	assign advance  = !valid_s1 || !cmd_full;
	assign full     = !advance;
	assign cmd_push = valid_s1;
	assign cmd      = cmd_s1;

	// Classify the incoming item
	always_comb begin
		digit_off    = byte_value - CH_ZERO;
		cls_in.digit = digit_off[3:0];
		priority if (kind) begin
			cls_in.cls = CLS_END;
		end else if (byte_value == CH_COMMA) begin
			cls_in.cls = CLS_COMMA;
		end else if (byte_value >= CH_ZERO && byte_value <= CH_NINE) begin
			cls_in.cls = CLS_DIGIT;
		end else begin
			cls_in.cls = CLS_OTHER;
		end
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (advance && push) begin
			cmd_s1 <= cls_in;
		end
	end

endmodule

// File: src/cpr_back.sv
// ----------------------------------------------------------------------------
// cpr_back
// Record engine: accumulates decimal fields, checks them, and builds the
// result with its routing lane when the end item arrives.
// ----------------------------------------------------------------------------
module cpr_back #(
	parameter int NUM_LANES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	input  cpr_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output cpr_pkg::res_t res
);
	import cpr_pkg::*;

	// Remainder width and the wrap correction (2^64 mod lanes)
	localparam int RW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
	localparam int TW = $clog2(32 * NUM_LANES);

	function automatic int unsigned wrap_mod(input int unsigned n);
		int unsigned c;
		c = 1;
		for (int i = 0; i < 64; i++) begin
			c = c * 2;
			if (c >= n) begin
				c = c - n;
			end
		end
		return c;
	endfunction

	localparam int unsigned WRAP_C = wrap_mod(NUM_LANES);
	localparam int unsigned WRAP_ADJ = NUM_LANES - WRAP_C;

	logic [63:0]   acc_q;
	logic [RW-1:0] rem_q;
	logic [2:0]    fields_q;
	logic          empty_q;
	logic          bad_q;
	logic          err_q;
	logic [63:0]   req_q;
	logic [63:0]   user_q;
	logic [31:0]   item_q;
	logic [31:0]   qty_q;
	logic [63:0]   time_q;
	logic [RW-1:0] req_rem_q;
	logic [RW-1:0] user_rem_q;

	logic [67:0]   mul10;
	logic [3:0]    wraps;
	logic [TW-1:0] t_rem;
	logic [RW-1:0] rem_nxt;
	logic          open;
	logic          closing;
	logic          err_a;
	logic [2:0]    fields_a;
	logic [63:0]   req_a;
	logic [63:0]   user_a;
	logic [31:0]   item_a;
	logic [31:0]   qty_a;
	logic [63:0]   time_a;
	logic [RW-1:0] req_rem_a;
	logic [RW-1:0] user_rem_a;
	logic [RW-1:0] key_rem;
	logic [RW+1:0] key_ext;
	logic          ok;

	// Decimal step: acc * 10 + digit, with the wrap count kept for the remainder
	always_comb begin
		mul10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 68'(cmd.digit);
		wraps = mul10[67:64];
	end

	// Running remainder of the wrapped value: 10r + d - wraps * 2^64 (mod lanes)
	always_comb begin
		t_rem = TW'(rem_q) * TW'(10) + TW'(cmd.digit) + TW'(wraps) * TW'(WRAP_ADJ);
		for (int k = 4; k >= 0; k--) begin
			if (t_rem >= TW'(NUM_LANES << k)) begin
				t_rem = t_rem - TW'(NUM_LANES << k);
			end
		end
		rem_nxt = t_rem[RW-1:0];
	end

	// Field close: checks and saved values as seen after the close
	always_comb begin
		open    = (fields_q < MAX_FIELDS);
		closing = open && (cmd.cls == CLS_COMMA || cmd.cls == CLS_END);
		err_a   = err_q;
		if (closing) begin
			if (fields_q < REQ_FIELDS) begin
				if (empty_q || bad_q) begin
					err_a = 1'b1;
				end
				if (fields_q >= F_ITEM && |acc_q[63:32]) begin
					err_a = 1'b1;
				end
			end else if (bad_q) begin
				err_a = 1'b1;
			end
		end
		fields_a   = closing ? fields_q + 3'd1 : fields_q;
		req_a      = (closing && fields_q == F_REQUEST)  ? acc_q        : req_q;
		user_a     = (closing && fields_q == F_USER)     ? acc_q        : user_q;
		item_a     = (closing && fields_q == F_ITEM)     ? acc_q[31:0]  : item_q;
		qty_a      = (closing && fields_q == F_QUANTITY) ? acc_q[31:0]  : qty_q;
		time_a     = (closing && fields_q == F_TIME)     ? acc_q        : time_q;
		req_rem_a  = (closing && fields_q == F_REQUEST)  ? rem_q        : req_rem_q;
		user_rem_a = (closing && fields_q == F_USER)     ? rem_q        : user_rem_q;
	end

	// Result build and handshake
	always_comb begin
		cmd_pop  = !cmd_empty && (cmd.cls != CLS_END || !res_full);
		res_push = cmd_pop && (cmd.cls == CLS_END);
		ok       = !err_a && (fields_a >= REQ_FIELDS);
		key_rem  = (user_a != 64'd0) ? user_rem_a : req_rem_a;
		key_ext  = (RW + 2)'(key_rem);
		res.valid_res  = ok;
		res.req_id     = ok ? req_a  : 64'd0;
		res.user_id    = ok ? user_a : 64'd0;
		res.item_id    = ok ? item_a : 32'd0;
		res.quantity   = ok ? qty_a  : 32'd0;
		res.timestamp  = ok ? time_a : 64'd0;
		res.lane       = ok ? key_ext[1:0] : 2'd0;
	end

	// Record state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			rem_q      <= '0;
			fields_q   <= '0;
			empty_q    <= 1'b1;
			bad_q      <= 1'b0;
			err_q      <= 1'b0;
			req_q      <= '0;
			user_q     <= '0;
			item_q     <= '0;
			qty_q      <= '0;
			time_q     <= '0;
			req_rem_q  <= '0;
			user_rem_q <= '0;
		end else if (cmd_pop) begin
			unique case (cmd.cls)
				CLS_DIGIT: begin
					if (open) begin
						acc_q   <= mul10[63:0];
						rem_q   <= rem_nxt;
						empty_q <= 1'b0;
					end
				end
				CLS_OTHER: begin
					if (open) begin
						empty_q <= 1'b0;
						bad_q   <= 1'b1;
					end
				end
				CLS_COMMA: begin
					if (closing) begin
						acc_q      <= '0;
						rem_q      <= '0;
						empty_q    <= 1'b1;
						bad_q      <= 1'b0;
						err_q      <= err_a;
						fields_q   <= fields_a;
						req_q      <= req_a;
						user_q     <= user_a;
						item_q     <= item_a;
						qty_q      <= qty_a;
						time_q     <= time_a;
						req_rem_q  <= req_rem_a;
						user_rem_q <= user_rem_a;
					end
				end
				CLS_END: begin
					acc_q      <= '0;
					rem_q      <= '0;
					fields_q   <= '0;
					empty_q    <= 1'b1;
					bad_q      <= 1'b0;
					err_q      <= 1'b0;
					req_q      <= '0;
					user_q     <= '0;
					item_q     <= '0;
					qty_q      <= '0;
					time_q     <= '0;
					req_rem_q  <= '0;
					user_rem_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Checks
	a_fields_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fields_q <= MAX_FIELDS)
		else $error("field count beyond five");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rem_q) < NUM_LANES && 32'(req_rem_q) < NUM_LANES && 32'(user_rem_q) < NUM_LANES)
		else $error("remainder out of range");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (fields_q == 3'd0 && empty_q && !err_q && acc_q == 64'd0))
		else $error("record state not cleared after end item");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res.valid_res) |-> (res.lane == 2'd0 && res.req_id == 64'd0))
		else $error("rejected record carries nonzero fields");

endmodule

// File: src/csv_order_record_parse_route_unit.sv
// ----------------------------------------------------------------------------
// csv_order_record_parse_route_unit
// Path: front stage register, command queue, record engine, result queue, ports.
// Throughput: one item per cycle while no full queue holds the flow; the engine has no busy state.
// Two-entry queues sit between front and back and on the result side.
// Reset: arst_n clears all parse state and empties both queues at once.
// ----------------------------------------------------------------------------
module csv_order_record_parse_route_unit #(
	parameter int NUM_LANES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [7:0]  byte_value,
	output logic        empty,
	input  logic        pop,
	output logic        valid_res,
	output logic [63:0] req_id,
	output logic [63:0] user_id,
	output logic [31:0] item_id,
	output logic [31:0] quantity,
	output logic [63:0] timestamp,
	output logic [1:0]  lane
);
	import cpr_pkg::*;

	logic cmd_push;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic res_push;
	logic res_full;
	res_t res_in;
	res_t res_out;

	// Front end: accept and classify
	cpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.byte_value(byte_value),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full)
	);

	// Queue between front and back
	cpr_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(2)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_out),
		.empty (cmd_empty)
	);

	// Record engine
	cpr_back #(
		.NUM_LANES(NUM_LANES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_out),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	// Result queue
	cpr_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign valid_res  = res_out.valid_res;
	assign req_id     = res_out.req_id;
	assign user_id    = res_out.user_id;
	assign item_id    = res_out.item_id;
	assign quantity   = res_out.quantity;
	assign timestamp  = res_out.timestamp;
	assign lane       = res_out.lane;

endmodule
